[rtl/spq_pkg.sv]
package spq_pkg;

    localparam int COST_W       = 24;
    localparam int POS_W        = 16;
    localparam int COUNT_W      = 7;
    localparam int DEF_CAPACITY = 64;

    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_REMOVE   = 2'd1,
        REQ_PEEK     = 2'd2,
        REQ_CONTAINS = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CMP,
        S_INS_PLACE,
        S_REMOVE,
        S_CON_CHK,
        S_HEAD_RD,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic ins_rd;
        logic ins_shift;
        logic ins_place;
        logic remove;
        logic scan_rd;
        logic scan_chk;
        logic head_rd;
        logic finish;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic full;
        logic empty;
        logic rem_zero;
        logic rem_one;
        logic shift_go;
        logic match;
        logic out_free;
    } sts_t;

endpackage

[rtl/spq_ram.sv]
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/spq_ctrl.sv]
module spq_ctrl
    import spq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (sts.req)
                    REQ_INSERT: begin
                        if (sts.full) begin
                            state_next = S_HEAD_RD;
                        end else if (sts.rem_zero) begin
                            state_next = S_INS_PLACE;
                        end else begin
                            cmd.ins_rd = 1'b1;
                            state_next = S_INS_CMP;
                        end
                    end
                    REQ_REMOVE: begin
                        state_next = sts.empty ? S_HEAD_RD : S_REMOVE;
                    end
                    REQ_PEEK: begin
                        state_next = S_HEAD_RD;
                    end
                    REQ_CONTAINS: begin
                        if (sts.rem_zero) begin
                            state_next = S_HEAD_RD;
                        end else begin
                            cmd.scan_rd = 1'b1;
                            state_next  = S_CON_CHK;
                        end
                    end
                    default: begin
                        state_next = S_HEAD_RD;
                    end
                endcase
            end
            S_INS_CMP: begin
                // walk down from the tail, moving each entry with cost >= new one up a slot
                if (sts.shift_go) begin
                    cmd.ins_shift = 1'b1;
                    if (sts.rem_one) begin
                        state_next = S_INS_PLACE;
                    end
                end else begin
                    state_next = S_INS_PLACE;
                end
            end
            S_INS_PLACE: begin
                cmd.ins_place = 1'b1;
                state_next    = S_HEAD_RD;
            end
            S_REMOVE: begin
                cmd.remove = 1'b1;
                state_next = S_HEAD_RD;
            end
            S_CON_CHK: begin
                cmd.scan_chk = 1'b1;
                if (sts.match || sts.rem_zero) begin
                    state_next = S_HEAD_RD;
                end else begin
                    cmd.scan_rd = 1'b1;
                end
            end
            S_HEAD_RD: begin
                cmd.head_rd = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/spq_datapath.sv]
module spq_datapath
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [1:0]         s_req_type,
    input  logic [COST_W-1:0]  s_entry_cost,
    input  logic [POS_W-1:0]   s_pos_x,
    input  logic [POS_W-1:0]   s_pos_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [COST_W-1:0]  m_head_cost,
    output logic [POS_W-1:0]   m_head_x,
    output logic [POS_W-1:0]   m_head_y,
    output logic               m_found,
    output logic [COUNT_W-1:0] m_count,
    output logic               m_is_empty
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [AW-1:0]    LAST_ADDR = AW'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] CAP_SUM   = SUM_W'(CAPACITY);

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_ADDR : a - 1'b1;
    endfunction

    // request held for the whole transaction
    req_t              req_reg;
    entry_t            new_reg;
    status_t           status_reg;
    logic              found_reg;

    // circular store: head_ptr is logical slot 0
    logic [AW-1:0]     head_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [AW-1:0]     ptr_reg;
    logic [AW-1:0]     wp_reg;
    logic [CNT_W-1:0]  rem_reg;

    logic              m_valid_reg;
    status_t           m_status_reg;
    entry_t            m_head_reg;
    logic              m_found_reg;
    logic [CNT_W-1:0]  m_count_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [ENTRY_W-1:0] rd_word;
    entry_t            rd_data;

    logic [SUM_W-1:0]  tail_sum;
    logic [AW-1:0]     tail_ptr;
    logic [AW-1:0]     wp_dec;
    status_t           status_next;
    logic              empty;
    logic              full;

    assign rd_data = entry_t'(rd_word);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_CNT);
    assign wp_dec  = addr_dec(wp_reg);

    always_comb begin
        tail_sum = SUM_W'(head_ptr_reg) + SUM_W'(count_reg);
        if (tail_sum >= CAP_SUM) begin
            tail_sum = tail_sum - CAP_SUM;
        end
        tail_ptr = tail_sum[AW-1:0];
    end

    always_comb begin
        status_next = ST_OK;
        case (req_t'(s_req_type))
            REQ_INSERT:   status_next = full ? ST_FULL : ST_OK;
            REQ_REMOVE:   status_next = empty ? ST_EMPTY : ST_OK;
            REQ_PEEK:     status_next = empty ? ST_EMPTY : ST_OK;
            REQ_CONTAINS: status_next = ST_OK;
            default:      status_next = ST_OK;
        endcase
    end

    always_comb begin
        wr_en   = cmd.ins_shift | cmd.ins_place;
        wr_addr = wp_reg;
        wr_data = cmd.ins_place ? new_reg : rd_data;
        rd_en   = cmd.ins_rd | cmd.ins_shift | cmd.scan_rd | cmd.head_rd;
        rd_addr = head_ptr_reg;
        if (cmd.ins_rd) begin
            rd_addr = wp_dec;
        end else if (cmd.ins_shift) begin
            rd_addr = addr_dec(wp_dec);
        end else if (cmd.scan_rd) begin
            rd_addr = ptr_reg;
        end
    end

    spq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_ptr_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.ins_place) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.remove) begin
                count_reg    <= count_reg - 1'b1;
                head_ptr_reg <= addr_inc(head_ptr_reg);
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= req_t'(s_req_type);
            new_reg    <= '{cost: s_entry_cost, x: s_pos_x, y: s_pos_y};
            status_reg <= status_next;
            found_reg  <= 1'b0;
            ptr_reg    <= head_ptr_reg;
            wp_reg     <= tail_ptr;
            rem_reg    <= count_reg;
        end
        if (cmd.ins_shift) begin
            wp_reg  <= wp_dec;
            rem_reg <= rem_reg - 1'b1;
        end
        if (cmd.scan_rd) begin
            ptr_reg <= addr_inc(ptr_reg);
            rem_reg <= rem_reg - 1'b1;
        end
        if (cmd.scan_chk && sts.match) begin
            found_reg <= 1'b1;
        end
        if (cmd.finish) begin
            m_status_reg <= status_reg;
            m_head_reg   <= empty ? '0 : rd_data;
            m_found_reg  <= found_reg;
            m_count_reg  <= count_reg;
        end
    end

    always_comb begin
        sts.req      = req_reg;
        sts.full     = full;
        sts.empty    = empty;
        sts.rem_zero = (rem_reg == '0);
        sts.rem_one  = (rem_reg == CNT_W'(1));
        sts.shift_go = (rd_data.cost >= new_reg.cost);
        sts.match    = (rd_data.x == new_reg.x) && (rd_data.y == new_reg.y);
        sts.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_head_cost = m_head_reg.cost;
    assign m_head_x    = m_head_reg.x;
    assign m_head_y    = m_head_reg.y;
    assign m_found     = m_found_reg;
    assign m_count     = COUNT_W'(m_count_reg);
    assign m_is_empty  = (m_count_reg == '0);

endmodule

[rtl/sorted_priority_queue.sv]
// Sorted priority queue, open list for path search.
// Input channel s_*: one request per transaction (insert, remove head, peek
// head, contains position). Result channel m_*: exactly one result per
// request, carrying status, head entry after the operation, found flag for
// contains, entry count and empty flag.
// Entries live in a single-port-write / single-port-read circular store of
// CAPACITY slots, kept in ascending cost order; a remove only advances the
// head pointer, an insert walks down from the tail one slot per cycle.
// Each request runs dispatch, its operation (if any), a head read and finish
// before m_valid; an insert moves each entry with cost >= the new cost in
// turn, and a contains reads entries until the first match or the last one.
// A new request is accepted in the cycle after the previous result is loaded
// into the output register, so requests do not overlap; the insert and
// contains walks go over the store's read port.
// Reset (synchronous, aresetn low) empties the queue at once; store contents
// are not cleared, and the data of unwritten slots is never used.
// If the receiver stalls, the finished result waits in the output register
// and the block holds the following result until m_ready frees it.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [COST_W-1:0]  s_entry_cost,
    input  logic [POS_W-1:0]   s_pos_x,
    input  logic [POS_W-1:0]   s_pos_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [COST_W-1:0]  m_head_cost,
    output logic [POS_W-1:0]   m_head_x,
    output logic [POS_W-1:0]   m_head_y,
    output logic               m_found,
    output logic [COUNT_W-1:0] m_count,
    output logic               m_is_empty
);

    cmd_t cmd;
    sts_t sts;

    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    spq_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_req_type   (s_req_type),
        .s_entry_cost (s_entry_cost),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_head_cost  (m_head_cost),
        .m_head_x     (m_head_x),
        .m_head_y     (m_head_y),
        .m_found      (m_found),
        .m_count      (m_count),
        .m_is_empty   (m_is_empty)
    );

endmodule
